[hdl/hsvrgb_pkg.sv]
// ============================================================================
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB converter.
// ============================================================================
package hsvrgb_pkg;

    // Default channel resolution (M = 2^CHANNEL_BITS - 1)
    localparam int CHANNEL_BITS_DEF = 8;

    // Port widths
    localparam int HUE_W    = 13;
    localparam int CFG_W    = 9;
    localparam int COLOR_W  = 8;
    localparam int PACKED_W = 24;

    // Hue geometry: six sectors of 960 sixteenths of a degree
    localparam int SECTOR_STEPS   = 960;
    localparam int NUM_SECTORS    = 6;
    localparam int MAX_RAW_SECTOR = 8;    // 8191 / 960, before wrapping
    localparam int OFFSET_W       = 10;
    localparam int SECTOR_W       = 3;
    localparam int RAW_SECTOR_W   = 4;

    // Q0.8 fractions
    localparam int ONE_Q8 = 256;
    localparam int FULL_N = ONE_Q8 * SECTOR_STEPS;   // weight for a factor of one

    // Datapath widths
    localparam int N_W    = 18;   // weight, up to FULL_N
    localparam int PROD_W = 26;   // value * weight, up to 256 * FULL_N

    // Denominator 256*256*960 = 2^22 * 15
    localparam int SCALE_SHIFT = 22;
    localparam int SCALE_ODD   = 15;

    // Register reset values
    localparam logic [CFG_W-1:0] SAT_RESET = CFG_W'(204);
    localparam logic [CFG_W-1:0] VAL_RESET = CFG_W'(51);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_SATURATION = 1'b0,
        CFG_VALUE      = 1'b1
    } cfg_index_t;

    // Hue sectors, named by the colours they run between
    typedef enum logic [SECTOR_W-1:0] {
        SEC_RED_YELLOW     = 3'd0,
        SEC_YELLOW_GREEN   = 3'd1,
        SEC_GREEN_CYAN     = 3'd2,
        SEC_CYAN_BLUE      = 3'd3,
        SEC_BLUE_MAGENTA   = 3'd4,
        SEC_MAGENTA_RED    = 3'd5
    } sector_t;

    // Position of a hue on the circle
    typedef struct packed {
        sector_t               sector;
        logic [OFFSET_W-1:0]   offset;
    } hue_pos_t;

    // Fractions above one saturate to one
    function automatic logic [CFG_W-1:0] clamp_q8(input logic [CFG_W-1:0] x);
        logic [CFG_W-1:0] res;
        res = (x > CFG_W'(ONE_Q8)) ? CFG_W'(ONE_Q8) : x;
        return res;
    endfunction

endpackage

[hdl/hsvrgb_hue_decode.sv]
// ============================================================================
// hsvrgb_hue_decode
// Splits a hue into sector and offset within the sector, with wrap of
// out-of-range hues. One register stage.
// ============================================================================
module hsvrgb_hue_decode
(
    input  logic                           clk,
    input  logic [hsvrgb_pkg::HUE_W-1:0]   hue,
    output hsvrgb_pkg::hue_pos_t           pos
);

    logic [hsvrgb_pkg::RAW_SECTOR_W-1:0] raw;
    logic [hsvrgb_pkg::HUE_W-1:0]        base;
    hsvrgb_pkg::hue_pos_t                pos_next;
    hsvrgb_pkg::hue_pos_t                pos_reg;

    // Raw sector by comparing against each sector boundary
    always_comb
    begin
        raw = '0;
        for (int k = 1; k <= hsvrgb_pkg::MAX_RAW_SECTOR; k++)
        begin
            if (hue >= hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::SECTOR_STEPS))
            begin
                raw = raw + 1'b1;
            end
        end
        base = hsvrgb_pkg::HUE_W'(raw * hsvrgb_pkg::SECTOR_STEPS);
        pos_next.offset = hsvrgb_pkg::OFFSET_W'(hue - base);
        // hues past the circle wrap back to the first sectors
        if (raw >= hsvrgb_pkg::RAW_SECTOR_W'(hsvrgb_pkg::NUM_SECTORS))
        begin
            pos_next.sector = hsvrgb_pkg::sector_t'(hsvrgb_pkg::SECTOR_W'(
                raw - hsvrgb_pkg::RAW_SECTOR_W'(hsvrgb_pkg::NUM_SECTORS)));
        end
        else
        begin
            pos_next.sector = hsvrgb_pkg::sector_t'(raw[hsvrgb_pkg::SECTOR_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    assign pos = pos_reg;

endmodule

[hdl/hsvrgb_channel.sv]
// ============================================================================
// hsvrgb_channel
// One channel level: floor(M * value * weight / (256*256*960)).
// Three register stages: product, scale by M, divide by 15.
// ============================================================================
module hsvrgb_channel
#(
    parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
)
(
    input  logic                          clk,
    input  logic [hsvrgb_pkg::CFG_W-1:0]  value,
    input  logic [hsvrgb_pkg::N_W-1:0]    weight,
    output logic [CHANNEL_BITS-1:0]       level
);

    localparam int MUL_W     = hsvrgb_pkg::CFG_W + hsvrgb_pkg::N_W;
    localparam int SCALED_W  = hsvrgb_pkg::PROD_W + CHANNEL_BITS;
    localparam int X_W       = CHANNEL_BITS + 4;          // up to 15 * M
    localparam int DIV_SHIFT = CHANNEL_BITS + 8;
    localparam int RECIP_W   = CHANNEL_BITS + 5;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** DIV_SHIFT) / hsvrgb_pkg::SCALE_ODD + 1);
    localparam int QPROD_W   = X_W + RECIP_W;

    logic [MUL_W-1:0]                  mul_full;
    logic [hsvrgb_pkg::PROD_W-1:0]     prod_reg;
    logic [SCALED_W-1:0]               scaled;
    logic [X_W-1:0]                    x_next;
    logic [X_W-1:0]                    x_reg;
    logic [QPROD_W-1:0]                qprod;
    logic [CHANNEL_BITS-1:0]           level_next;
    logic [CHANNEL_BITS-1:0]           level_reg;

    // value * weight
    assign mul_full = {{hsvrgb_pkg::N_W{1'b0}}, value} * {{hsvrgb_pkg::CFG_W{1'b0}}, weight};

    // times M = 2^bits - 1, then drop the power-of-two part of the denominator
    assign scaled = {prod_reg, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, prod_reg};
    assign x_next = scaled[SCALED_W-1:hsvrgb_pkg::SCALE_SHIFT];

    // floor(x / 15) by reciprocal; exact for x below 2^DIV_SHIFT / 14
    assign qprod      = {{RECIP_W{1'b0}}, x_reg} * {{X_W{1'b0}}, RECIP};
    assign level_next = qprod[DIV_SHIFT+CHANNEL_BITS-1:DIV_SHIFT];

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_full[hsvrgb_pkg::PROD_W-1:0];
        x_reg     <= x_next;
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

[hdl/hsv_to_rgb_converter_core.sv]
// ============================================================================
// hsv_to_rgb_converter_core
// Six-sector HSV to RGB conversion of one hue per clock.
// ============================================================================
// One hue is taken on every cycle that start is high; busy is always low.
// Each transaction comes out of the last stage as a one-cycle done strobe with
// red, green, blue and packed_color. The pipeline has six stages: hue decode,
// sector weights, value multiply, scale by the channel maximum, divide by 15,
// and colour select. Saturation and value are written through the cfg port
// (always ready) and must only change while no transaction is in flight.
// ============================================================================
module hsv_to_rgb_converter_core
#(
    parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // transaction in
    input  logic                             start,
    output logic                             busy,
    input  logic [hsvrgb_pkg::HUE_W-1:0]     hue,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [hsvrgb_pkg::CFG_W-1:0]     cfg_data,
    // result
    output logic                             done,
    output logic [hsvrgb_pkg::COLOR_W-1:0]   red,
    output logic [hsvrgb_pkg::COLOR_W-1:0]   green,
    output logic [hsvrgb_pkg::COLOR_W-1:0]   blue,
    output logic [hsvrgb_pkg::PACKED_W-1:0]  packed_color
);

    localparam int STAGES  = 6;
    localparam int SEC_DLY = 4;
    localparam int CB      = CHANNEL_BITS;
    localparam int RS_W    = hsvrgb_pkg::CFG_W + hsvrgb_pkg::OFFSET_W;

    logic                               accept;
    logic [STAGES-1:0]                  vld_reg;
    logic [STAGES-1:0]                  vld_next;

    logic [hsvrgb_pkg::CFG_W-1:0]       sat_reg;
    logic [hsvrgb_pkg::CFG_W-1:0]       val_reg;

    hsvrgb_pkg::hue_pos_t               pos;
    logic [hsvrgb_pkg::CFG_W-1:0]       s1_reg;
    logic [hsvrgb_pkg::CFG_W-1:0]       v1_reg;

    logic [hsvrgb_pkg::OFFSET_W-1:0]    comp;
    logic [RS_W-1:0]                    rs;
    logic [RS_W-1:0]                    cs;
    logic [hsvrgb_pkg::N_W-1:0]         np_next;
    logic [hsvrgb_pkg::N_W-1:0]         nq_next;
    logic [hsvrgb_pkg::N_W-1:0]         nt_next;
    logic [hsvrgb_pkg::N_W-1:0]         np_reg;
    logic [hsvrgb_pkg::N_W-1:0]         nq_reg;
    logic [hsvrgb_pkg::N_W-1:0]         nt_reg;
    logic [hsvrgb_pkg::CFG_W-1:0]       v2_reg;

    hsvrgb_pkg::sector_t                sec_reg [SEC_DLY];

    logic [CB-1:0]                      lv_v;
    logic [CB-1:0]                      lv_p;
    logic [CB-1:0]                      lv_q;
    logic [CB-1:0]                      lv_t;

    logic [CB-1:0]                      red_next;
    logic [CB-1:0]                      green_next;
    logic [CB-1:0]                      blue_next;
    logic [CB-1:0]                      red_reg;
    logic [CB-1:0]                      green_reg;
    logic [CB-1:0]                      blue_reg;

    logic [CB+hsvrgb_pkg::COLOR_W-1:0]  red_ext;
    logic [CB+hsvrgb_pkg::COLOR_W-1:0]  green_ext;
    logic [CB+hsvrgb_pkg::COLOR_W-1:0]  blue_ext;
    logic [3*CB+hsvrgb_pkg::PACKED_W-1:0] packed_ext;

    // Handshakes: fully pipelined, never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= hsvrgb_pkg::SAT_RESET;
            val_reg <= hsvrgb_pkg::VAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (hsvrgb_pkg::cfg_index_t'(cfg_index))
                hsvrgb_pkg::CFG_SATURATION: sat_reg <= cfg_data;
                hsvrgb_pkg::CFG_VALUE:      val_reg <= cfg_data;
            endcase
        end
    end

    // Valid bits travel alongside the data
    assign vld_next = {vld_reg[STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: hue decode, clamped fractions
    hsvrgb_hue_decode u_decode
    (
        .clk (clk),
        .hue (hue),
        .pos (pos)
    );

    always_ff @(posedge clk)
    begin
        s1_reg <= hsvrgb_pkg::clamp_q8(sat_reg);
        v1_reg <= hsvrgb_pkg::clamp_q8(val_reg);
    end

    // Stage 2: weights for p, q and t
    assign comp = hsvrgb_pkg::OFFSET_W'(hsvrgb_pkg::SECTOR_STEPS) - pos.offset;
    assign rs   = {{hsvrgb_pkg::OFFSET_W{1'b0}}, s1_reg} * {{hsvrgb_pkg::CFG_W{1'b0}}, pos.offset};
    assign cs   = {{hsvrgb_pkg::OFFSET_W{1'b0}}, s1_reg} * {{hsvrgb_pkg::CFG_W{1'b0}}, comp};

    assign np_next = hsvrgb_pkg::N_W'((hsvrgb_pkg::ONE_Q8 - int'(s1_reg))
                                      * hsvrgb_pkg::SECTOR_STEPS);
    assign nq_next = hsvrgb_pkg::N_W'(hsvrgb_pkg::FULL_N - int'(rs));
    assign nt_next = hsvrgb_pkg::N_W'(hsvrgb_pkg::FULL_N - int'(cs));

    always_ff @(posedge clk)
    begin
        np_reg <= np_next;
        nq_reg <= nq_next;
        nt_reg <= nt_next;
        v2_reg <= v1_reg;
    end

    // Sector follows the data down to the select stage
    always_ff @(posedge clk)
    begin
        sec_reg[0] <= pos.sector;
        for (int i = 1; i < SEC_DLY; i++)
        begin
            sec_reg[i] <= sec_reg[i-1];
        end
    end

    // Stages 3 to 5: channel levels
    hsvrgb_channel #(.CHANNEL_BITS(CB)) u_chan_v
    (
        .clk    (clk),
        .value  (v2_reg),
        .weight (hsvrgb_pkg::N_W'(hsvrgb_pkg::FULL_N)),
        .level  (lv_v)
    );

    hsvrgb_channel #(.CHANNEL_BITS(CB)) u_chan_p
    (
        .clk    (clk),
        .value  (v2_reg),
        .weight (np_reg),
        .level  (lv_p)
    );

    hsvrgb_channel #(.CHANNEL_BITS(CB)) u_chan_q
    (
        .clk    (clk),
        .value  (v2_reg),
        .weight (nq_reg),
        .level  (lv_q)
    );

    hsvrgb_channel #(.CHANNEL_BITS(CB)) u_chan_t
    (
        .clk    (clk),
        .value  (v2_reg),
        .weight (nt_reg),
        .level  (lv_t)
    );

    // Stage 6: sector pattern select
    always_comb
    begin
        unique case (sec_reg[SEC_DLY-1])
            hsvrgb_pkg::SEC_RED_YELLOW:
            begin
                red_next = lv_v; green_next = lv_t; blue_next = lv_p;
            end
            hsvrgb_pkg::SEC_YELLOW_GREEN:
            begin
                red_next = lv_q; green_next = lv_v; blue_next = lv_p;
            end
            hsvrgb_pkg::SEC_GREEN_CYAN:
            begin
                red_next = lv_p; green_next = lv_v; blue_next = lv_t;
            end
            hsvrgb_pkg::SEC_CYAN_BLUE:
            begin
                red_next = lv_p; green_next = lv_q; blue_next = lv_v;
            end
            hsvrgb_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next = lv_t; green_next = lv_p; blue_next = lv_v;
            end
            default:
            begin
                red_next = lv_v; green_next = lv_p; blue_next = lv_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[STAGES-2])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // Result ports
    assign red_ext    = {{hsvrgb_pkg::COLOR_W{1'b0}}, red_reg};
    assign green_ext  = {{hsvrgb_pkg::COLOR_W{1'b0}}, green_reg};
    assign blue_ext   = {{hsvrgb_pkg::COLOR_W{1'b0}}, blue_reg};
    assign packed_ext = {{hsvrgb_pkg::PACKED_W{1'b0}}, blue_reg, green_reg, red_reg};

    assign done         = vld_reg[STAGES-1];
    assign red          = red_ext[hsvrgb_pkg::COLOR_W-1:0];
    assign green        = green_ext[hsvrgb_pkg::COLOR_W-1:0];
    assign blue         = blue_ext[hsvrgb_pkg::COLOR_W-1:0];
    assign packed_color = packed_ext[hsvrgb_pkg::PACKED_W-1:0];

    // Assertions
    // every transaction gives exactly one result
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("result missing six cycles after a transaction");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 6))
        else $error("result without a matching transaction");

    // decoded offset stays inside its sector
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (pos.offset < hsvrgb_pkg::OFFSET_W'(hsvrgb_pkg::SECTOR_STEPS)))
        else $error("hue offset outside sector");

    // wrapped sector reaching the select stage is one of six
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STAGES-2] |->
            (sec_reg[SEC_DLY-1] <= hsvrgb_pkg::SEC_MAGENTA_RED))
        else $error("sector not wrapped");

endmodule
